// ----- hw/rtl/lcs_pkg.sv -----
// ----------------------------------------------------------------------------
// lcs_pkg
// shared types, constants, the linearization rom and the channel numerator
// ----------------------------------------------------------------------------
package lcs_pkg;

    localparam int LumaFracBits = 16;
    localparam int LinW         = 17;
    localparam int WW           = LumaFracBits + 1;
    localparam int YW           = LumaFracBits + 1;
    localparam int HW           = LumaFracBits + 2;
    localparam int ProdW        = WW + LinW;
    localparam int SumW         = ProdW + 2;
    localparam int EvalDepth    = 8;
    localparam int CntW         = 4;

    localparam logic [WW-1:0] WeightR =
        WW'(((64'd2126 << LumaFracBits) + 64'd5000) / 64'd10000);
    localparam logic [WW-1:0] WeightG =
        WW'(((64'd7152 << LumaFracBits) + 64'd5000) / 64'd10000);
    localparam logic [WW-1:0] WeightB =
        WW'(((64'd722 << LumaFracBits) + 64'd5000) / 64'd10000);
    localparam logic [HW-1:0] LumaOffset =
        HW'(((64'd1 << LumaFracBits) + 64'd10) / 64'd20);

    // divide by 6000 as multiply by floor(2^26 / 6000) plus one correction
    localparam logic [13:0] DivRecip = 14'd11184;
    localparam int          DivShift = 26;
    localparam logic [20:0] ChanDiv  = 21'd6000;

    localparam logic [6:0]  SatMax   = 7'd100;
    localparam logic [8:0]  HueMax   = 9'd359;

    // configuration register indexes
    localparam logic CfgSaturation = 1'b0;
    localparam logic CfgStartLight = 1'b1;

    typedef struct packed {
        logic [8:0]  hue_degrees;
        logic [12:0] contrast_floor;
        logic [7:0]  background_red;
        logic [7:0]  background_green;
        logic [7:0]  background_blue;
    } t_in_req;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_out_rsp;

    // channel 0 red, 1 green, 2 blue
    typedef logic [2:0][7:0] t_chan_arr;

    typedef struct packed {
        t_chan_arr       pix;
        logic [YW-1:0]   y;
        logic [HW-1:0]   hi;
        logic [HW-1:0]   lo;
        logic            meet;
    } t_eval_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BG,
        ST_BG_WAIT,
        ST_START,
        ST_START_WAIT,
        ST_WALK,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef logic [255:0][LinW-1:0] t_lin_rom;

    // srgb linearization, q1.16, evaluated at elaboration
    function automatic t_lin_rom lin_rom_build();
        t_lin_rom    rom;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] r;
        logic [63:0] cand;
        logic [63:0] p;
        logic [63:0] c64;
        for (int c = 0; c < 256; c++) begin
            c64 = 64'(c);
            if (c <= 10) begin
                rom[c] = LinW'((c64 * 64'd6553600 + 64'd164730) / 64'd329460);
            end else if (c == 255) begin
                rom[c] = LinW'(64'd65536);
            end else begin
                t = (((c64 * 64'd1000 + 64'd14025) << 32) + 64'd134512) / 64'd269025;
                s = (t * t) >> 32;
                r = 64'd0;
                for (int b = 31; b >= 0; b--) begin
                    cand = r | (64'd1 << b);
                    p = (cand * cand) >> 32;
                    p = (p * p) >> 32;
                    p = (p * cand) >> 32;
                    if (p <= s) begin
                        r = cand;
                    end
                end
                rom[c] = LinW'((((s * r) >> 32) + 64'd32768) >> 16);
            end
        end
        return rom;
    endfunction

    localparam t_lin_rom LinRom = lin_rom_build();

    // channel numerator at hue position x, with the rounding half added
    function automatic logic [20:0] chan_num(
        input logic [8:0]  x,
        input logic [15:0] f,
        input logic [15:0] q
    );
        logic [15:0] d;
        logic [20:0] n;
        d = q - f;
        priority if (x < 9'd60) begin
            n = 21'(f) * 21'd60 + 21'(d) * 21'(x);
        end else if (x < 9'd180) begin
            n = 21'(q) * 21'd60;
        end else if (x < 9'd240) begin
            n = 21'(f) * 21'd60 + 21'(d) * 21'(9'd240 - x);
        end else begin
            n = 21'(f) * 21'd60;
        end
        return n + 21'd3000;
    endfunction

endpackage

// ----- hw/rtl/lcs_hsl.sv -----
// ----------------------------------------------------------------------------
// lcs_hsl
// four stage hsl to rgb byte conversion, background bypass
// ----------------------------------------------------------------------------
module lcs_hsl
    import lcs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_is_bg,
    input  logic [7:0] i_light,
    input  logic [8:0] i_hue,
    input  logic [6:0] i_sat,
    input  t_chan_arr  i_bg,
    output logic       o_valid,
    output t_chan_arr  o_pix
);

    logic              r1_valid, r2_valid, r3_valid, r4_valid;
    logic              r1_is_bg, r2_is_bg, r3_is_bg;
    logic [15:0]       r1_q, r1_f;
    logic [2:0][8:0]   r1_x;
    logic [2:0][20:0]  r2_m, r3_m;
    logic [2:0][7:0]   r3_qe;
    t_chan_arr         r4_pix;

    logic [15:0]       n1_q, n1_f, light16, sat16;
    logic [9:0]        hue_r;
    logic [2:0][8:0]   n1_x;
    t_chan_arr         n4_pix;
    logic [2:0][20:0]  rem;

    always_comb begin
        light16 = 16'(i_light);
        sat16   = 16'(i_sat);
        n1_q = (i_light <= 8'd127) ? light16 * (16'd100 + sat16)
             : light16 * 16'd100 + sat16 * 16'd255 - light16 * sat16;
        n1_f = 16'd200 * light16 - n1_q;
        hue_r = 10'(i_hue) + 10'd120;
        n1_x[0] = (hue_r > 10'd360) ? 9'(hue_r - 10'd360) : hue_r[8:0];
        n1_x[1] = i_hue;
        n1_x[2] = (i_hue < 9'd120) ? i_hue + 9'd240 : i_hue - 9'd120;
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            rem[ch] = r3_m[ch] - 21'(r3_qe[ch]) * ChanDiv;
            n4_pix[ch] = (rem[ch] >= ChanDiv) ? r3_qe[ch] + 8'd1 : r3_qe[ch];
        end
        if (r3_is_bg) begin
            n4_pix = i_bg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_is_bg <= i_is_bg;
        r1_q     <= n1_q;
        r1_f     <= n1_f;
        r1_x     <= n1_x;
        r2_is_bg <= r1_is_bg;
        r3_is_bg <= r2_is_bg;
        r3_m     <= r2_m;
        r4_pix   <= n4_pix;
        for (int ch = 0; ch < 3; ch++) begin
            r2_m[ch]  <= chan_num(r1_x[ch], r1_f, r1_q);
            r3_qe[ch] <= 8'((35'(r2_m[ch]) * 35'(DivRecip)) >> DivShift);
        end
    end

    assign o_valid = r4_valid;
    assign o_pix   = r4_pix;

endmodule

// ----- hw/rtl/lcs_luma.sv -----
// ----------------------------------------------------------------------------
// lcs_luma
// four stage relative luminance and contrast check against the background
// ----------------------------------------------------------------------------
module lcs_luma
    import lcs_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  t_chan_arr     i_pix,
    input  logic [YW-1:0] i_ybg,
    input  logic [12:0]   i_minc,
    output logic          o_valid,
    output t_eval_rsp     o_rsp
);

    localparam int MW = HW + 13;
    localparam logic [2:0][WW-1:0] Weights = {WeightB, WeightG, WeightR};

    logic                   r5_valid, r6_valid, r7_valid, r8_valid;
    t_chan_arr              r5_pix, r6_pix, r7_pix;
    logic [2:0][LinW-1:0]   r5_lin;
    logic [2:0][ProdW-1:0]  r6_prod;
    logic [YW-1:0]          r7_y;
    t_eval_rsp              r8_rsp;

    logic [SumW-1:0]        sum;
    logic [HW-1:0]          hi, lo;
    t_eval_rsp              n8_rsp;

    always_comb begin
        sum = SumW'(r6_prod[0]) + SumW'(r6_prod[1]) + SumW'(r6_prod[2])
            + SumW'(32768);
    end

    always_comb begin
        hi = ((r7_y > i_ybg) ? HW'(r7_y) : HW'(i_ybg)) + LumaOffset;
        lo = ((r7_y > i_ybg) ? HW'(i_ybg) : HW'(r7_y)) + LumaOffset;
        n8_rsp.pix  = r7_pix;
        n8_rsp.y    = r7_y;
        n8_rsp.hi   = hi;
        n8_rsp.lo   = lo;
        n8_rsp.meet = (MW'(hi) << 8) >= MW'(i_minc) * MW'(lo);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
            r7_valid <= 1'b0;
            r8_valid <= 1'b0;
        end else begin
            r5_valid <= i_valid;
            r6_valid <= r5_valid;
            r7_valid <= r6_valid;
            r8_valid <= r7_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_pix <= i_pix;
        r6_pix <= r5_pix;
        r7_pix <= r6_pix;
        for (int ch = 0; ch < 3; ch++) begin
            r5_lin[ch]  <= LinRom[i_pix[ch]];
            r6_prod[ch] <= ProdW'(Weights[ch]) * ProdW'(r5_lin[ch]);
        end
        r7_y   <= YW'(sum >> 16);
        r8_rsp <= n8_rsp;
    end

    assign o_valid = r8_valid;
    assign o_rsp   = r8_rsp;

endmodule

// ----- hw/rtl/legible_color_search_unit.sv -----
// ----------------------------------------------------------------------------
// legible_color_search_unit
// hsl lightness search for a color meeting a wcag contrast minimum
// ----------------------------------------------------------------------------
// sequence: the background luminance is evaluated first, then the start color;
//   if the start color passes it is loaded as the response; else the walk issues
//   up to 255 candidates (one pass from the start each way) until one passes,
//   drains the 8 stage evaluator and registers the best candidate as the response
// requests: one at a time, the next is taken in the cycle after the
//   response is loaded
// reset: synchronous active low; saturation 52, start lightness 140, idle
// ----------------------------------------------------------------------------
module legible_color_search_unit
    import lcs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_in_req    i_req,
    output logic       o_valid,
    input  logic       i_ready,
    output t_out_rsp   o_rsp
);

    // configuration
    logic [6:0]  r_cfg_sat;
    logic [7:0]  r_cfg_start;

    // request context, captured at accept; background luminance after its evaluation
    logic [8:0]  r_hue;
    logic [6:0]  r_sat;
    logic [7:0]  r_start;
    logic [12:0] r_minc;
    t_chan_arr   r_bg;
    logic [YW-1:0] r_ybg;

    // best candidate so far
    t_chan_arr   r_best;
    logic [HW-1:0] r_bhi, r_blo;

    // walk issue side
    logic [9:0]  r_wl;
    logic        r_wup;
    logic        r_wpass;
    logic        r_wdone;
    logic [CntW-1:0] r_cnt;

    t_state      r_state, n_state;

    t_out_rsp    r_out;
    logic        r_out_valid;

    // evaluator interface
    logic        ev_valid, ev_is_bg;
    logic [7:0]  ev_light;
    logic        hsl_valid;
    t_chan_arr   hsl_pix;
    logic        res_valid;
    t_eval_rsp   res;

    logic        in_range, better, out_load;
    logic [2*HW-1:0] cross_new, cross_best;

    assign in_range   = (r_wl[9:8] == 2'b00);
    assign cross_new  = (2*HW)'(res.hi) * (2*HW)'(r_blo);
    assign cross_best = (2*HW)'(r_bhi) * (2*HW)'(res.lo);
    assign better     = cross_new > cross_best;
    assign out_load   = (r_state == ST_DONE) && (!r_out_valid || i_ready);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:       if (i_valid) n_state = ST_BG;
            ST_BG:         n_state = ST_BG_WAIT;
            ST_BG_WAIT:    if (res_valid) n_state = ST_START;
            ST_START:      n_state = ST_START_WAIT;
            ST_START_WAIT: if (res_valid) n_state = res.meet ? ST_DONE : ST_WALK;
            ST_WALK: begin
                priority if (res_valid && res.meet) begin
                    n_state = ST_DRAIN;
                end else if (r_wdone && r_cnt == '0) begin
                    n_state = ST_DONE;
                end
            end
            ST_DRAIN:      if (r_cnt == '0) n_state = ST_DONE;
            ST_DONE:       if (!r_out_valid || i_ready) n_state = ST_IDLE;
            default:       n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_ready  = 1'b0;
        ev_valid = 1'b0;
        ev_is_bg = 1'b0;
        ev_light = r_start;
        unique case (r_state)
            ST_IDLE:  o_ready = 1'b1;
            ST_BG: begin
                ev_valid = 1'b1;
                ev_is_bg = 1'b1;
            end
            ST_START: ev_valid = 1'b1;
            ST_WALK: begin
                ev_valid = !r_wdone && in_range;
                ev_light = r_wl[7:0];
            end
            default: ;
        endcase
    end

    lcs_hsl u_hsl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (ev_valid),
        .i_is_bg (ev_is_bg),
        .i_light (ev_light),
        .i_hue   (r_hue),
        .i_sat   (r_sat),
        .i_bg    (r_bg),
        .o_valid (hsl_valid),
        .o_pix   (hsl_pix)
    );

    lcs_luma u_luma (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (hsl_valid),
        .i_pix   (hsl_pix),
        .i_ybg   (r_ybg),
        .i_minc  (r_minc),
        .o_valid (res_valid),
        .o_rsp   (res)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cfg_sat   <= 7'd52;
            r_cfg_start <= 8'd140;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_wdone     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CfgSaturation: r_cfg_sat   <= i_cfg_data[6:0];
                    CfgStartLight: r_cfg_start <= i_cfg_data;
                    default: ;
                endcase
            end
            // in-flight count of evaluator requests
            r_cnt <= r_cnt + CntW'(ev_valid) - CntW'(res_valid);
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            // walk bookkeeping
            if (r_state == ST_START_WAIT && res_valid) begin
                r_wdone <= 1'b0;
            end else if (r_state == ST_WALK && !r_wdone && !in_range && r_wpass) begin
                r_wdone <= 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_valid) begin
            r_hue   <= (i_req.hue_degrees > HueMax) ? HueMax : i_req.hue_degrees;
            r_sat   <= (r_cfg_sat > SatMax) ? SatMax : r_cfg_sat;
            r_start <= r_cfg_start;
            r_minc  <= i_req.contrast_floor;
            r_bg    <= {i_req.background_blue, i_req.background_green,
                        i_req.background_red};
        end
        if (r_state == ST_BG_WAIT && res_valid) begin
            r_ybg <= res.y;
        end
        if (r_state == ST_START_WAIT && res_valid) begin
            r_best  <= res.pix;
            r_bhi   <= res.hi;
            r_blo   <= res.lo;
            // equal luminance walks up first
            r_wup   <= !(r_ybg > res.y);
            r_wl    <= (r_ybg > res.y) ? 10'(r_start) - 10'd1 : 10'(r_start) + 10'd1;
            r_wpass <= 1'b0;
        end
        if (r_state == ST_WALK) begin
            if (res_valid) begin
                if (better || res.meet) begin
                    r_best <= res.pix;
                end
                if (better) begin
                    r_bhi <= res.hi;
                    r_blo <= res.lo;
                end
            end
            if (!r_wdone) begin
                if (in_range) begin
                    r_wl <= r_wup ? r_wl + 10'd1 : r_wl - 10'd1;
                end else if (!r_wpass) begin
                    // second pass from the start the other way
                    r_wpass <= 1'b1;
                    r_wup   <= !r_wup;
                    r_wl    <= r_wup ? 10'(r_start) - 10'd1 : 10'(r_start) + 10'd1;
                end
            end
        end
        if (out_load) begin
            r_out.red   <= r_best[0];
            r_out.green <= r_best[1];
            r_out.blue  <= r_best[2];
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

    // results only come back for requests that were issued
    a_res_issued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> r_cnt != '0)
        else $error("evaluator result without request in flight");

    // never more in flight than the evaluator holds
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CntW'(EvalDepth))
        else $error("in-flight count overflow");

    // completion always produces a result on the next cycle
    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> o_valid)
        else $error("finished search did not present a result");

    // a new request is never taken while the evaluator still has work
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |-> r_cnt == '0)
        else $error("request accepted with evaluator busy");

endmodule
